@@ rtl/core/lsq_pkg.sv @@
// ----------------------------------------------------------------------------
// lsq_pkg
// Shared widths, constants and types for the largest-ones-square stream.
// ----------------------------------------------------------------------------
`default_nettype none

package lsq_pkg;

  // line buffer geometry
  localparam int MaxCols = 1024;
  localparam int ColW    = $clog2(MaxCols);

  // field widths
  localparam int LenW  = 11;
  localparam int SideW = 11;
  localparam int AreaW = 21;

  // row_length after reset
  localparam logic [LenW-1:0] LenReset = 11'd1024;

  // per-pixel control carried from the input stage into the side stage
  typedef struct packed {
    logic            pixel;
    logic            last;
    logic [ColW-1:0] col;
    logic            col_zero;
    logic            first_row;
  } lsq_tag_t;

endpackage

`default_nettype wire

@@ rtl/core/lsq_pixel_if.sv @@
// ----------------------------------------------------------------------------
// lsq_pixel_if
// Pixel input channel: valid/ready handshake with one image bit per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsq_pixel_if;
  logic valid;
  logic ready;
  logic pixel;
  logic frame_last;

  modport source (output valid, output pixel, output frame_last, input ready);
  modport sink   (input valid, input pixel, input frame_last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lsq_result_if.sv @@
// ----------------------------------------------------------------------------
// lsq_result_if
// Result channel: valid/ready handshake, one word per accepted pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsq_result_if;
  logic                           valid;
  logic                           ready;
  logic [lsq_pkg::SideW-1:0]      side_here;
  logic [lsq_pkg::SideW-1:0]      best_side;
  logic [lsq_pkg::AreaW-1:0]      best_area;
  logic                           frame_done;

  modport source (output valid, output side_here, output best_side, output best_area,
                  output frame_done, input ready);
  modport sink   (input valid, input side_here, input best_side, input best_area,
                  input frame_done, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lsq_line_ram.sv @@
// ----------------------------------------------------------------------------
// lsq_line_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsq_line_ram #(
  parameter int Depth = 1024,
  parameter int Width = 11
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data in the cycle after re
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lsq_col_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsq_col_ctrl
// Input stage: row length register, column counter and first-row flag.
// Tags each accepted pixel and supplies the line buffer read address.
// ----------------------------------------------------------------------------
`default_nettype none

module lsq_col_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [lsq_pkg::LenW-1:0]  cfg_wr_data,
  input  wire logic                      accept,
  input  wire logic                      pixel,
  input  wire logic                      frame_last,
  output lsq_pkg::lsq_tag_t              tag
);

  logic [lsq_pkg::LenW-1:0] row_length;
  logic [lsq_pkg::ColW-1:0] col;
  logic                     first_row;
  logic [lsq_pkg::ColW-1:0] last_col;

  // last column index: zero length acts as one, oversize clamps to the buffer
  always_comb begin
    if (row_length == '0) begin
      last_col = '0;
    end else if (row_length > lsq_pkg::LenW'(lsq_pkg::MaxCols)) begin
      last_col = lsq_pkg::ColW'(lsq_pkg::MaxCols - 1);
    end else begin
      last_col = lsq_pkg::ColW'(row_length - lsq_pkg::LenW'(1));
    end
  end

  // tag for the pixel on the input
  always_comb begin
    tag.pixel     = pixel;
    tag.last      = frame_last;
    tag.col       = col;
    tag.col_zero  = (col == '0);
    tag.first_row = first_row;
  end

  // raster position; a register write or a frame end restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= lsq_pkg::LenReset;
      col        <= '0;
      first_row  <= 1'b1;
    end else if (cfg_wr_en) begin
      row_length <= cfg_wr_data;
      col        <= '0;
      first_row  <= 1'b1;
    end else if (accept) begin
      if (frame_last) begin
        col       <= '0;
        first_row <= 1'b1;
      end else if (col >= last_col) begin
        col       <= '0;
        first_row <= 1'b0;
      end else begin
        col <= col + lsq_pkg::ColW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lsq_side_pipe.sv @@
// ----------------------------------------------------------------------------
// lsq_side_pipe
// Side stage and output register. Takes the line buffer read data, forms
// the square side, writes it back and tracks the running best.
// ----------------------------------------------------------------------------
`default_nettype none

module lsq_side_pipe (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic                       load,
  input  wire lsq_pkg::lsq_tag_t          in_tag,
  output logic                            can_load,
  input  wire logic [lsq_pkg::SideW-1:0]  ram_rdata,
  output logic                            ram_we,
  output logic [lsq_pkg::ColW-1:0]        ram_waddr,
  output logic [lsq_pkg::SideW-1:0]       ram_wdata,
  lsq_result_if.source                    res
);

  logic                        s1_valid;
  lsq_pkg::lsq_tag_t           s1_tag;
  logic [lsq_pkg::SideW-1:0]   left_side;
  logic [lsq_pkg::SideW-1:0]   diag_side;
  logic [lsq_pkg::SideW-1:0]   running_best;

  logic                        advance;
  logic [lsq_pkg::SideW-1:0]   up;
  logic [lsq_pkg::SideW-1:0]   min_ld;
  logic [lsq_pkg::SideW-1:0]   min_all;
  logic [lsq_pkg::SideW-1:0]   side;
  logic [lsq_pkg::SideW-1:0]   best_next;
  logic [2*lsq_pkg::SideW-1:0] area_full;

  // handshake between stages
  assign advance  = s1_valid && (!res.valid || res.ready);
  assign can_load = !s1_valid || advance;

  // side at this pixel: zero, one on the frame edge, else min of neighbors plus one
  always_comb begin
    up      = s1_tag.first_row ? '0 : ram_rdata;
    min_ld  = (left_side < diag_side) ? left_side : diag_side;
    min_all = (up < min_ld) ? up : min_ld;
    if (!s1_tag.pixel) begin
      side = '0;
    end else if (s1_tag.first_row || s1_tag.col_zero) begin
      side = lsq_pkg::SideW'(1);
    end else begin
      side = min_all + lsq_pkg::SideW'(1);
    end
    best_next = (side > running_best) ? side : running_best;
    area_full = {{lsq_pkg::SideW{1'b0}}, best_next} * {{lsq_pkg::SideW{1'b0}}, best_next};
  end

  // write back into the line buffer
  assign ram_we    = advance;
  assign ram_waddr = s1_tag.col;
  assign ram_wdata = side;

  // side stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      left_side    <= '0;
      diag_side    <= '0;
      running_best <= '0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        left_side    <= '0;
        diag_side    <= '0;
        running_best <= '0;
      end else if (advance) begin
        left_side    <= side;
        diag_side    <= up;
        running_best <= s1_tag.last ? '0 : best_next;
      end
    end
  end

  // tag follows the read request
  always_ff @(posedge clk) begin
    if (load) begin
      s1_tag <= in_tag;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.side_here  <= side;
      res.best_side  <= best_next;
      res.best_area  <= area_full[lsq_pkg::AreaW-1:0];
      res.frame_done <= s1_tag.last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/largest_ones_square_stream.sv @@
// ----------------------------------------------------------------------------
// largest_ones_square_stream
// Streaming largest all-ones square over a raster binary image.
// ----------------------------------------------------------------------------
// Path: an accepted pixel goes through the side stage registers and then the
//   output word register. Throughput: one pixel per cycle unless the result
//   channel stalls, set by the line buffer doing one read (next column, on
//   accept) and one write-back (current column) per cycle.
// Reset: row_length returns to 1024, a new frame starts at column 0 in the
//   first row, the running best clears; the line buffer is not cleared.
`default_nettype none

module largest_ones_square_stream (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [lsq_pkg::LenW-1:0]  cfg_wr_data,
  lsq_pixel_if.sink                      pix,
  lsq_result_if.source                   res
);

  lsq_pkg::lsq_tag_t           tag;
  logic                        accept;
  logic                        can_load;
  logic [lsq_pkg::SideW-1:0]   ram_rdata;
  logic                        ram_we;
  logic [lsq_pkg::ColW-1:0]    ram_waddr;
  logic [lsq_pkg::SideW-1:0]   ram_wdata;

  // input handshake
  assign pix.ready = can_load;
  assign accept    = pix.valid && can_load;

  lsq_col_ctrl u_col_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .pixel       (pix.pixel),
    .frame_last  (pix.frame_last),
    .tag         (tag)
  );

  // previous row sides
  lsq_line_ram #(
    .Depth (lsq_pkg::MaxCols),
    .Width (lsq_pkg::SideW)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (tag.col),
    .rdata (ram_rdata)
  );

  lsq_side_pipe u_side_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .load      (accept),
    .in_tag    (tag),
    .can_load  (can_load),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .res       (res)
  );

endmodule

`default_nettype wire

@@ rtl/core/lsq_checker.sv @@
// ----------------------------------------------------------------------------
// lsq_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsq_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [lsq_pkg::SideW-1:0]  side_here,
  input wire logic [lsq_pkg::SideW-1:0]  best_side,
  input wire logic [lsq_pkg::AreaW-1:0]  best_area,
  input wire logic                       frame_done
);

  logic [2*lsq_pkg::SideW-1:0] best_sq;

  assign best_sq = {{lsq_pkg::SideW{1'b0}}, best_side} * {{lsq_pkg::SideW{1'b0}}, best_side};

  // area word is the square of the best side
  a_area: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> best_area == best_sq[lsq_pkg::AreaW-1:0])
    else $error("best_area is not best_side squared");

  // running best covers the side at this pixel
  a_best: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> side_here <= best_side)
    else $error("side_here exceeds best_side");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(side_here) && $stable(best_side)
      && $stable(frame_done))
    else $error("result word changed while stalled");

  // reset empties the output
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind largest_ones_square_stream lsq_checker u_lsq_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (res.valid),
  .out_ready  (res.ready),
  .side_here  (res.side_here),
  .best_side  (res.best_side),
  .best_area  (res.best_area),
  .frame_done (res.frame_done)
);

`default_nettype wire
